/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the biquad filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge while reset is released.
`define BQBP_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bqbp assertion failed");

// Checked at every rising edge, reset included.
`define BQBP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bqbp assertion failed");

`else

`define BQBP_ASSERT_RST(lbl, clk, rst_n, prop)
`define BQBP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/core/bqbp_pkg.sv */
// ---------------------------------------------------------------------------
// bqbp_pkg
// Shared constants and types of the biquad bandpass filter.
// ---------------------------------------------------------------------------
package bqbp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 20;
  localparam int CFG_IDX_W = 3;
  // Width of one state slice fed to the shared multiplier.
  localparam int CHUNK_W   = 32;

  localparam int DEF_COEF_FRAC_BITS = 16;
  localparam int DEF_STATE_WIDTH    = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN_2 = 3'd4;

  // Reset coefficients: 2 kHz bandpass, bandwidth 0.1, 48 kHz sampling.
  localparam logic signed [COEF_W-1:0] FF_GAIN_0_RST = 20'sd589;
  localparam logic signed [COEF_W-1:0] FF_GAIN_1_RST = 20'sd0;
  localparam logic signed [COEF_W-1:0] FF_GAIN_2_RST = -20'sd589;
  localparam logic signed [COEF_W-1:0] FB_GAIN_1_RST = 20'sd125467;
  localparam logic signed [COEF_W-1:0] FB_GAIN_2_RST = -20'sd64357;

  typedef struct packed {
    logic clr;  // clear the accumulator
    logic mul;  // issue one coefficient by slice product
  } mac_ctrl_t;

endpackage

/* rtl/core/bqbp_mac.sv */
// ---------------------------------------------------------------------------
// bqbp_mac
// Shared multiply-accumulate unit with registered product and rounding.
// ---------------------------------------------------------------------------
module bqbp_mac import bqbp_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int STATE_WIDTH    = DEF_STATE_WIDTH,
  localparam int NCHUNK = (STATE_WIDTH + CHUNK_W - 1) / CHUNK_W,
  localparam int CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1,
  localparam int PAD_W  = NCHUNK * CHUNK_W,
  localparam int ACC_W  = COEF_W + PAD_W + 3,
  localparam int RND_W  = ACC_W - COEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctrl,
  input  logic [CIDX_W-1:0]        chunk_idx,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [CHUNK_W:0]  opnd,
  output logic signed [RND_W-1:0]  rnd
);

  localparam int PROD_W = COEF_W + CHUNK_W + 1;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic [CIDX_W-1:0]        prod_idx_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rsum;
  logic signed [RND_W-1:0]  rnd_r;

  always_comb begin
    prod_ext = ACC_W'(prod_r) <<< (CHUNK_W * int'(prod_idx_r));
    acc_nxt  = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + prod_ext;
    end
    rsum = acc_r + HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.mul;
    end
    prod_r     <= PROD_W'(coef) * PROD_W'(opnd);
    prod_idx_r <= chunk_idx;
    acc_r      <= acc_nxt;
    // Round half up, then drop the fraction bits of the coefficients.
    rnd_r      <= rsum[ACC_W-1:COEF_FRAC_BITS];
  end

  assign rnd = rnd_r;

endmodule

/* rtl/core/bqbp_sat.sv */
// ---------------------------------------------------------------------------
// bqbp_sat
// Signed saturation to a narrower width with a clip flag.
// ---------------------------------------------------------------------------
module bqbp_sat #(
  parameter int IW = 40,
  parameter int OW = 16
) (
  input  logic signed [IW-1:0] din,
  output logic signed [OW-1:0] dout,
  output logic                 clip
);

  localparam logic signed [IW-1:0] MAXV =
    signed'({{(IW-OW+1){1'b0}}, {(OW-1){1'b1}}});
  localparam logic signed [IW-1:0] MINV = ~MAXV;

  always_comb begin
    clip = 1'b0;
    dout = din[OW-1:0];
    if (din > MAXV) begin
      dout = MAXV[OW-1:0];
      clip = 1'b1;
    end else if (din < MINV) begin
      dout = MINV[OW-1:0];
      clip = 1'b1;
    end
  end

endmodule

/* rtl/core/biquad_bandpass_filter_unit.sv */
// Each delay word is split into NCHUNK = ceil(STATE_WIDTH/32) slices of 32 bits.
// A new item is taken only from idle, once the last result is loaded, since
// the single shared multiplier forms all five products in turn.
// Reset (synchronous, rst_n low) loads the bandpass coefficients, zeroes both
// delay words and drops out_valid; it takes effect at the next rising edge.
// ---------------------------------------------------------------------------
// biquad_bandpass_filter_unit
// Direct form II biquad section with a shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_bandpass_filter_unit import bqbp_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int STATE_WIDTH    = DEF_STATE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_wdata,
  // Input sample channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped
);

  localparam int NCHUNK = (STATE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = NCHUNK * CHUNK_W;
  localparam int ACC_W  = COEF_W + PAD_W + 3;
  localparam int RND_W  = ACC_W - COEF_FRAC_BITS;
  localparam logic [CIDX_W-1:0] LAST_CHUNK = CIDX_W'(NCHUNK - 1);

  // Product terms in the order the shared unit works through them. The first
  // two build the new delay input w, the last three build the output y.
  localparam logic [2:0] TERM_FB1 = 3'd0;
  localparam logic [2:0] TERM_FB2 = 3'd1;
  localparam logic [2:0] TERM_FF0 = 3'd2;
  localparam logic [2:0] TERM_FF1 = 3'd3;
  localparam logic [2:0] TERM_FF2 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_FB_ACC,
    ST_FB_RND,
    ST_FB_SAT,
    ST_Y_MUL,
    ST_Y_ACC,
    ST_Y_RND,
    ST_Y_SAT
  } state_t;

  state_t state_r, state_nxt;

  // Coefficient registers.
  logic signed [COEF_W-1:0] ff0_r, ff1_r, ff2_r, fb1_r, fb2_r;

  // Filter state and working registers.
  logic signed [STATE_WIDTH-1:0] delay_one_r, delay_one_nxt;
  logic signed [STATE_WIDTH-1:0] delay_two_r, delay_two_nxt;
  logic signed [STATE_WIDTH-1:0] w_r, w_nxt;
  logic signed [SAMPLE_W-1:0]    x_r, x_nxt;
  logic                          clip_w_r, clip_w_nxt;
  logic [2:0]                    term_r, term_nxt;
  logic [CIDX_W-1:0]             chunk_r, chunk_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] sample_out_r, sample_out_nxt;
  logic                       clipped_r, clipped_nxt;

  // Shared unit interface.
  mac_ctrl_t                     mac_ctrl;
  logic signed [COEF_W-1:0]      mac_coef;
  logic signed [STATE_WIDTH-1:0] opnd_full;
  logic signed [PAD_W-1:0]       opnd_pad;
  logic [CHUNK_W-1:0]            opnd_slice;
  logic signed [CHUNK_W:0]       mac_opnd;
  logic signed [RND_W-1:0]       mac_rnd;

  // Saturation paths.
  logic signed [RND_W:0]          w_sum;
  logic signed [STATE_WIDTH-1:0]  w_sat;
  logic                           w_clip;
  logic signed [SAMPLE_W-1:0]     y_sat;
  logic                           y_clip;

  logic in_acc;
  logic out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Pick the coefficient and the state word of the current product term.
  always_comb begin
    case (term_r)
      TERM_FB1: begin
        mac_coef  = fb1_r;
        opnd_full = delay_one_r;
      end
      TERM_FB2: begin
        mac_coef  = fb2_r;
        opnd_full = delay_two_r;
      end
      TERM_FF0: begin
        mac_coef  = ff0_r;
        opnd_full = w_r;
      end
      TERM_FF1: begin
        mac_coef  = ff1_r;
        opnd_full = delay_one_r;
      end
      default: begin
        mac_coef  = ff2_r;
        opnd_full = delay_two_r;
      end
    endcase
    // The top slice carries the sign; lower slices are unsigned magnitudes.
    opnd_pad   = PAD_W'(opnd_full);
    opnd_slice = opnd_pad[chunk_r*CHUNK_W +: CHUNK_W];
    if (chunk_r == LAST_CHUNK) begin
      mac_opnd = signed'({opnd_slice[CHUNK_W-1], opnd_slice});
    end else begin
      mac_opnd = signed'({1'b0, opnd_slice});
    end
  end

  bqbp_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .chunk_idx (chunk_r),
    .coef      (mac_coef),
    .opnd      (mac_opnd),
    .rnd       (mac_rnd)
  );

  // The delay input adds the sample to the rounded feedback sum.
  assign w_sum = (RND_W+1)'(x_r) + (RND_W+1)'(mac_rnd);

  bqbp_sat #(
    .IW (RND_W+1),
    .OW (STATE_WIDTH)
  ) u_sat_w (
    .din  (w_sum),
    .dout (w_sat),
    .clip (w_clip)
  );

  bqbp_sat #(
    .IW (RND_W),
    .OW (SAMPLE_W)
  ) u_sat_y (
    .din  (mac_rnd),
    .dout (y_sat),
    .clip (y_clip)
  );

  // Sequencer. Each product term issues one multiply per state slice; after
  // the last issue of a group, the ACC state lets the product land in the
  // accumulator, the RND state registers the rounded sum and the SAT state saturates it.
  always_comb begin
    state_nxt      = state_r;
    term_nxt       = term_r;
    chunk_nxt      = chunk_r;
    x_nxt          = x_r;
    w_nxt          = w_r;
    clip_w_nxt     = clip_w_r;
    delay_one_nxt  = delay_one_r;
    delay_two_nxt  = delay_two_r;
    out_valid_nxt  = out_valid_r && out_stall;
    sample_out_nxt = sample_out_r;
    clipped_nxt    = clipped_r;
    mac_ctrl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt        = in_sample_in;
          term_nxt     = TERM_FB1;
          chunk_nxt    = '0;
          mac_ctrl.clr = 1'b1;
          state_nxt    = ST_FB_MUL;
        end
      end
      ST_FB_MUL, ST_Y_MUL: begin
        mac_ctrl.mul = 1'b1;
        if (chunk_r == LAST_CHUNK) begin
          chunk_nxt = '0;
          if (term_r == TERM_FB2) begin
            state_nxt = ST_FB_ACC;
          end else if (term_r == TERM_FF2) begin
            state_nxt = ST_Y_ACC;
          end else begin
            term_nxt = term_r + 3'd1;
          end
        end else begin
          chunk_nxt = chunk_r + CIDX_W'(1);
        end
      end
      ST_FB_ACC: begin
        state_nxt = ST_FB_RND;
      end
      ST_FB_RND: begin
        state_nxt = ST_FB_SAT;
      end
      ST_FB_SAT: begin
        w_nxt        = w_sat;
        clip_w_nxt   = w_clip;
        term_nxt     = TERM_FF0;
        chunk_nxt    = '0;
        mac_ctrl.clr = 1'b1;
        state_nxt    = ST_Y_MUL;
      end
      ST_Y_ACC: begin
        state_nxt = ST_Y_RND;
      end
      ST_Y_RND: begin
        state_nxt = ST_Y_SAT;
      end
      ST_Y_SAT: begin
        // Wait here until the output register is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          sample_out_nxt = y_sat;
          clipped_nxt    = clip_w_r || y_clip;
          delay_two_nxt  = delay_one_r;
          delay_one_nxt  = w_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      delay_one_r <= '0;
      delay_two_r <= '0;
      ff0_r       <= FF_GAIN_0_RST;
      ff1_r       <= FF_GAIN_1_RST;
      ff2_r       <= FF_GAIN_2_RST;
      fb1_r       <= FB_GAIN_1_RST;
      fb2_r       <= FB_GAIN_2_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      delay_one_r <= delay_one_nxt;
      delay_two_r <= delay_two_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FF_GAIN_0: ff0_r <= signed'(cfg_wdata);
          REG_FF_GAIN_1: ff1_r <= signed'(cfg_wdata);
          REG_FF_GAIN_2: ff2_r <= signed'(cfg_wdata);
          REG_FB_GAIN_1: fb1_r <= signed'(cfg_wdata);
          REG_FB_GAIN_2: fb2_r <= signed'(cfg_wdata);
          default: ;
        endcase
      end
    end
    term_r       <= term_nxt;
    chunk_r      <= chunk_nxt;
    x_r          <= x_nxt;
    w_r          <= w_nxt;
    clip_w_r     <= clip_w_nxt;
    sample_out_r <= sample_out_nxt;
    clipped_r    <= clipped_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = sample_out_r;
  assign out_clipped    = clipped_r;

  // An accepted item keeps the input side stalled on the following cycle.
  `BQBP_ASSERT_RST(a_busy_after_accept, clk, rst_n, in_acc |=> in_stall)
  // A new result only appears out of the final output step.
  `BQBP_ASSERT_RST(a_out_from_final, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_Y_SAT))
  // The delay line moves only when a result is loaded.
  `BQBP_ASSERT_RST(a_delay_shift, clk, rst_n, $past(rst_n) && !$stable(delay_one_r) |-> $past(state_r == ST_Y_SAT))
  // Reset empties the output register.
  `BQBP_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid_r)

endmodule

/* sim/bqbp_result_checker.sv */
// ---------------------------------------------------------------------------
// bqbp_result_checker
// Watches the configuration port and both channels of the biquad filter,
// predicts every result in fixed point and compares it field by field.
// ---------------------------------------------------------------------------
module bqbp_result_checker import bqbp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       out_clipped,
  output int                         fail_count,
  output int                         pending
);

  localparam int     FRAC       = DEF_COEF_FRAC_BITS;
  localparam int     STATE_W    = DEF_STATE_WIDTH;
  localparam longint ROUND_HALF = longint'(1) <<< (FRAC - 1);
  localparam longint STATE_MAX  = (longint'(1) <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN  = -STATE_MAX - 1;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } filter_result_t;

  logic signed [COEF_W-1:0]  ff_gain_0, ff_gain_1, ff_gain_2;
  logic signed [COEF_W-1:0]  fb_gain_1, fb_gain_2;
  logic signed [STATE_W-1:0] delay_one, delay_two;
  filter_result_t            expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Sums of exact products are rounded once, half toward plus infinity.
  function automatic longint round_frac(input longint acc);
    return (acc + ROUND_HALF) >>> FRAC;
  endfunction

  // One direct form II step: new delay input, output, then the delay shift.
  task automatic filter_step(input logic signed [SAMPLE_W-1:0] x);
    longint         fb_sum, ff_sum, w, y;
    logic           hit;
    filter_result_t r;
    hit    = 1'b0;
    fb_sum = longint'(fb_gain_1) * longint'(delay_one)
           + longint'(fb_gain_2) * longint'(delay_two);
    w = longint'(x) + round_frac(fb_sum);
    if (w > STATE_MAX) begin
      w   = STATE_MAX;
      hit = 1'b1;
    end else if (w < STATE_MIN) begin
      w   = STATE_MIN;
      hit = 1'b1;
    end
    ff_sum = longint'(ff_gain_0) * w
           + longint'(ff_gain_1) * longint'(delay_one)
           + longint'(ff_gain_2) * longint'(delay_two);
    y = round_frac(ff_sum);
    if (y > SAMPLE_MAX) begin
      y   = SAMPLE_MAX;
      hit = 1'b1;
    end else if (y < SAMPLE_MIN) begin
      y   = SAMPLE_MIN;
      hit = 1'b1;
    end
    delay_two = delay_one;
    delay_one = w[STATE_W-1:0];
    r.sample  = y[SAMPLE_W-1:0];
    r.clipped = hit;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    filter_result_t want;
    if (!rst_n) begin
      ff_gain_0 = FF_GAIN_0_RST;
      ff_gain_1 = FF_GAIN_1_RST;
      ff_gain_2 = FF_GAIN_2_RST;
      fb_gain_1 = FB_GAIN_1_RST;
      fb_gain_2 = FB_GAIN_2_RST;
      delay_one = '0;
      delay_two = '0;
      expected_results.delete();
    end else begin
      // A result accepted in the same cycle as an item belongs to an older item.
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: sample_out %0d, clipped %0b",
                 out_sample_out, out_clipped);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_sample_out !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   want.sample, out_sample_out);
            fail_count++;
          end
          if (out_clipped !== want.clipped) begin
            $error("clipped mismatch: expected %0b, actual %0b",
                   want.clipped, out_clipped);
            fail_count++;
          end
        end
      end
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_FF_GAIN_0: ff_gain_0 = cfg_wdata;
          REG_FF_GAIN_1: ff_gain_1 = cfg_wdata;
          REG_FF_GAIN_2: ff_gain_2 = cfg_wdata;
          REG_FB_GAIN_1: fb_gain_1 = cfg_wdata;
          REG_FB_GAIN_2: fb_gain_2 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        filter_step(in_sample_in);
      end
    end
    pending = expected_results.size();
  end

endmodule

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the biquad bandpass filter: directed samples at
// the field extremes and through both kinds of saturation, then random
// sample streams under several coefficient sets and idling patterns.
// ---------------------------------------------------------------------------
module tb;
  import bqbp_pkg::*;

  // Time the block takes to answer an item; one 32-bit slice per delay word by default.
  localparam int LATENCY     = 5 * ((DEF_STATE_WIDTH + CHUNK_W - 1) / CHUNK_W) + 6;
  localparam int TAIL_CYCLES = 4 * LATENCY;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 175;
  localparam int NUM_PHASES  = 6;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic signed [COEF_W-1:0] GAIN_MAX = 20'sh7FFFF;
  localparam logic signed [COEF_W-1:0] GAIN_MIN = 20'sh80000;
  // 1.0 in Q3.16, so a section with only this feedforward term passes x through.
  localparam logic signed [COEF_W-1:0] GAIN_UNITY = 20'sd65536;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_clipped;

  int          fail_count;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  biquad_bandpass_filter_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

  bqbp_result_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Period of 10 time units, the first rising edge at 5.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A hung handshake ends the run here instead of running forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls at random at the current rate. A hold-off request
  // from the stimulus makes it stall for a long stretch, which it counts
  // down itself while the sender keeps offering items.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // All tasks below are entered and left at a falling edge.
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // Registers are written only once every expected result has come back,
  // so the block is idle. Every item yields a result, so nothing is left
  // in flight once the count of outstanding results is zero.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic load_gains(input logic signed [COEF_W-1:0] ff0, input logic signed [COEF_W-1:0] ff1,
                            input logic signed [COEF_W-1:0] ff2, input logic signed [COEF_W-1:0] fb1,
                            input logic signed [COEF_W-1:0] fb2);
    write_reg(REG_FF_GAIN_0, ff0);
    write_reg(REG_FF_GAIN_1, ff1);
    write_reg(REG_FF_GAIN_2, ff2);
    write_reg(REG_FB_GAIN_1, fb1);
    write_reg(REG_FB_GAIN_2, fb2);
    cfg_we <= 1'b0;
  endtask

  // Indexes past the last register must leave every coefficient alone.
  task automatic write_unused_regs();
    for (int idx = int'(REG_FB_GAIN_2) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(idx[CFG_IDX_W-1:0], COEF_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // The sample is offered after a random gap and held until it is taken.
  // Each loop turn assigns in_valid once in its own time step.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] random_gain();
    logic [31:0] r;
    r = $urandom;
    return r[COEF_W-1:0];
  endfunction

  // Mostly full-range samples, with extremes, silence and small values
  // mixed in so that stable filters also ring down between bursts.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    int          v;
    r = $urandom;
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3, 4: begin
        v = $urandom_range(511);
        v = v - 256;
        return v[SAMPLE_W-1:0];
      end
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Writes to unused indexes right after reset; the reset bandpass
    // coefficients must still be in force for the directed samples.
    write_unused_regs();
    send_sample(16'sd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    // An impulse followed by silence shows the ringing of the resonator.
    send_sample(16'sh7FFF);
    repeat (5) send_sample(16'sd0);

    // Extreme coefficients drive the output into saturation at once and
    // the delay words soon after, first upward and then downward.
    load_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MAX, GAIN_MIN);
    repeat (4) send_sample(16'sh7FFF);
    repeat (4) send_sample(16'sh8000);

    // A pure pass-through clears the saturated state without any clipping.
    load_gains(GAIN_UNITY, '0, '0, '0, '0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd1234);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // The sender rarely idles against a slow receiver, then the other
      // way round, then neither side idles at all.
      case (phase)
        0, 1: begin
          tx_idle_pct = 12;
          rx_idle_pct = 87;
        end
        2, 3: begin
          tx_idle_pct = 87;
          rx_idle_pct = 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (phase)
        1: begin
          write_unused_regs();
          load_gains(random_gain(), random_gain(), random_gain(), random_gain(), random_gain());
        end
        2: load_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
        3: load_gains(random_gain(), random_gain(), random_gain(),
                      random_gain() >>> 3, random_gain() >>> 3);
        4: load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        default: load_gains(FF_GAIN_0_RST, FF_GAIN_1_RST, FF_GAIN_2_RST,
                            FB_GAIN_1_RST, FB_GAIN_2_RST);
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // The long hold-off fills the block until it stalls its input.
        if (phase == 4 && n == 20) hold_requests++;
        // Halfway through the last phase the sender waits for every result.
        if (phase == NUM_PHASES - 1 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_drained();
          @(negedge clk);
        end
        send_sample(random_sample());
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    // Any late, unexpected result would show up within this tail.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
